/* design/hsv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_pkg: shared widths, constants and stage types for the HSV to RGB core
// Hue is degrees in fixed point; levels use LEVEL_FRAC fraction bits.
// ----------------------------------------------------------------------------
package hsv_pkg;

	localparam int HUE_FRAC   = 6;
	localparam int LEVEL_FRAC = 12;
	localparam int HUE_W      = 15;
	localparam int LEVEL_W    = 13;
	localparam int CHAN_W     = 8;
	localparam int CHAN_MAX   = (1 << CHAN_W) - 1;

	// one 60-degree sector in hue units; 3840 = 15 * 2^(HUE_FRAC+2)
	localparam int SPAN       = 60 << HUE_FRAC;
	localparam int MAX_SECTOR = ((1 << HUE_W) - 1) / SPAN;
	localparam int SECTOR_W   = $clog2(MAX_SECTOR + 1);
	localparam int CENTER_W   = HUE_W + 2;
	localparam int WEIGHT_W   = $clog2(SPAN + 1);

	localparam int CHROMA_W   = 2 * LEVEL_W;
	localparam int MIX_W      = CHROMA_W + 2;
	localparam int PX_W       = CHROMA_W + WEIGHT_W;
	localparam int PM_W       = MIX_W + WEIGHT_W;
	localparam int SUM_W      = PM_W + 1;

	// 255 / (2^(2L) * SPAN) reduces to SCALE_MUL / 2^SCALE_SHIFT
	localparam int SCALE_MUL   = CHAN_MAX / (SPAN >> (HUE_FRAC + 2));
	localparam int SCALE_SHIFT = 2 * LEVEL_FRAC + HUE_FRAC + 2;

	typedef logic [SECTOR_W-1:0] sector_t;

	localparam sector_t SECTOR_RED_YELLOW    = SECTOR_W'(0);
	localparam sector_t SECTOR_YELLOW_GREEN  = SECTOR_W'(1);
	localparam sector_t SECTOR_GREEN_CYAN    = SECTOR_W'(2);
	localparam sector_t SECTOR_CYAN_BLUE     = SECTOR_W'(3);
	localparam sector_t SECTOR_BLUE_MAGENTA  = SECTOR_W'(4);
	localparam sector_t SECTOR_MAGENTA_RED   = SECTOR_W'(5);

	typedef struct packed {
		sector_t                   sector;
		logic [LEVEL_W-1:0]        level;
		logic [CHROMA_W-1:0]       chroma;
		logic signed [MIX_W-1:0]   mix;
		logic [WEIGHT_W-1:0]       weight;
	} front_t;

	typedef struct packed {
		sector_t                   sector;
		logic [LEVEL_W-1:0]        level;
		logic [PX_W-1:0]           prod_x;
		logic signed [PM_W-1:0]    prod_m;
	} mul_t;

endpackage

/* design/hsv_to_rgb_core.sv */
`timescale 1ns / 1ps
// Throughput: one item per clock while rgb_ready is high; an accepted item moves through
// five register stages in order, the fifth is the output register and drives rgb_valid.
// A stall only backs up into empty stages; pixel_ready drops only when all five are full.
// Reset: arst_n clears every stage valid bit at once; data registers are not reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb_core: HSV to 8-bit RGB converter
// Chroma/sector, ramp weight, products, sum, then scale and channel order.
// ----------------------------------------------------------------------------
module hsv_to_rgb_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pixel_valid,
	output logic                          pixel_ready,
	input  logic [hsv_pkg::HUE_W-1:0]     hue,
	input  logic [hsv_pkg::LEVEL_W-1:0]   saturation,
	input  logic [hsv_pkg::LEVEL_W-1:0]   brightness,
	output logic                          rgb_valid,
	input  logic                          rgb_ready,
	output logic [hsv_pkg::CHAN_W-1:0]    red,
	output logic [hsv_pkg::CHAN_W-1:0]    green,
	output logic [hsv_pkg::CHAN_W-1:0]    blue
);
	import hsv_pkg::*;

	logic     front_valid, front_ready;
	front_t   front;
	logic     mul_valid, mul_ready;
	mul_t     mul;

	hsv_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.hue         (hue),
		.saturation  (saturation),
		.brightness  (brightness),
		.front_valid (front_valid),
		.front_ready (front_ready),
		.front       (front)
	);

	hsv_mul u_mul (
		.clk         (clk),
		.arst_n      (arst_n),
		.front_valid (front_valid),
		.front_ready (front_ready),
		.front       (front),
		.mul_valid   (mul_valid),
		.mul_ready   (mul_ready),
		.mul         (mul)
	);

	hsv_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.mul_valid  (mul_valid),
		.mul_ready  (mul_ready),
		.mul        (mul),
		.rgb_valid  (rgb_valid),
		.rgb_ready  (rgb_ready),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	// input back-pressure only when the whole pipe is full and the sink stalls
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> rgb_valid && !rgb_ready && front_valid && mul_valid)
		else $error("input stalled while the pipeline has an empty stage");

endmodule

/* design/hsv_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_front: stages 1 and 2
// Stage 1 forms chroma and the hue sector, stage 2 the ramp weight and m.
// ----------------------------------------------------------------------------
module hsv_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pixel_valid,
	output logic                          pixel_ready,
	input  logic [hsv_pkg::HUE_W-1:0]     hue,
	input  logic [hsv_pkg::LEVEL_W-1:0]   saturation,
	input  logic [hsv_pkg::LEVEL_W-1:0]   brightness,
	output logic                          front_valid,
	input  logic                          front_ready,
	output hsv_pkg::front_t               front
);
	import hsv_pkg::*;

	logic                  adv1, adv2;
	logic                  valid_s1, valid_s2;
	logic [HUE_W-1:0]      hue_s1;
	sector_t               sector_s1;
	logic [CHROMA_W-1:0]   chroma_s1;
	logic [LEVEL_W-1:0]    level_s1;
	front_t                front_s2;

	sector_t               sector_d;
	logic [CENTER_W-1:0]   center_d;
	logic [CENTER_W-1:0]   hue_ext;
	logic [CENTER_W-1:0]   dist_d;
	front_t                front_d;

	assign adv2        = !valid_s2 || front_ready;
	assign adv1        = !valid_s1 || adv2;
	assign pixel_ready = adv1;

	always_comb begin
		sector_d = '0;
		for (int k = 1; k <= MAX_SECTOR; k++) begin
			if (hue >= HUE_W'(k * SPAN))
				sector_d = sector_d + SECTOR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv1)
			valid_s1 <= pixel_valid;
	end

	always_ff @(posedge clk) begin
		if (adv1 && pixel_valid) begin
			hue_s1    <= hue;
			sector_s1 <= sector_d;
			chroma_s1 <= CHROMA_W'(brightness) * CHROMA_W'(saturation);
			level_s1  <= brightness;
		end
	end

	// distance from the middle of the even/odd sector pair gives the ramp
	always_comb begin
		hue_ext  = CENTER_W'(hue_s1);
		center_d = CENTER_W'({sector_s1[SECTOR_W-1:1], 1'b1}) * CENTER_W'(SPAN);
		if (hue_ext >= center_d)
			dist_d = hue_ext - center_d;
		else
			dist_d = center_d - hue_ext;
		front_d.sector = sector_s1;
		front_d.level  = level_s1;
		front_d.chroma = chroma_s1;
		front_d.mix    = $signed(MIX_W'({level_s1, {LEVEL_FRAC{1'b0}}}))
			- $signed(MIX_W'(chroma_s1));
		if (dist_d > CENTER_W'(SPAN))
			front_d.weight = '0;
		else
			front_d.weight = WEIGHT_W'(CENTER_W'(SPAN) - dist_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv2)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1)
			front_s2 <= front_d;
	end

	assign front_valid = valid_s2;
	assign front       = front_s2;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv2 |=> valid_s1 && $stable(chroma_s1) && $stable(hue_s1))
		else $error("stage 1 item changed while stalled");

endmodule

/* design/hsv_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_mul: stage 3
// Multiplies chroma by the ramp weight and scales m by the sector span.
// ----------------------------------------------------------------------------
module hsv_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                front_valid,
	output logic                front_ready,
	input  hsv_pkg::front_t     front,
	output logic                mul_valid,
	input  logic                mul_ready,
	output hsv_pkg::mul_t       mul
);
	import hsv_pkg::*;

	localparam logic signed [PM_W-1:0] SPAN_S = PM_W'(SPAN);

	logic   adv3;
	logic   valid_s3;
	mul_t   mul_s3;
	mul_t   mul_d;

	assign adv3        = !valid_s3 || mul_ready;
	assign front_ready = adv3;

	always_comb begin
		mul_d.sector = front.sector;
		mul_d.level  = front.level;
		mul_d.prod_x = PX_W'(front.chroma) * PX_W'(front.weight);
		mul_d.prod_m = PM_W'(front.mix) * SPAN_S;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (adv3)
			valid_s3 <= front_valid;
	end

	always_ff @(posedge clk) begin
		if (adv3 && front_valid)
			mul_s3 <= mul_d;
	end

	assign mul_valid = valid_s3;
	assign mul       = mul_s3;

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !mul_ready |=> valid_s3 && $stable(mul_s3.prod_x))
		else $error("stage 3 item changed while stalled");

endmodule

/* design/hsv_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_out: stages 4 and 5
// Stage 4 sums the ramp channel, stage 5 scales to 8 bits and orders r, g, b.
// ----------------------------------------------------------------------------
module hsv_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          mul_valid,
	output logic                          mul_ready,
	input  hsv_pkg::mul_t                 mul,
	output logic                          rgb_valid,
	input  logic                          rgb_ready,
	output logic [hsv_pkg::CHAN_W-1:0]    red,
	output logic [hsv_pkg::CHAN_W-1:0]    green,
	output logic [hsv_pkg::CHAN_W-1:0]    blue
);
	import hsv_pkg::*;

	localparam int Z_W = SUM_W + 5;
	localparam int LP_W = LEVEL_W + CHAN_W;

	// floor(SCALE_MUL * y / 2^SCALE_SHIFT), clipped to 0..255
	function automatic logic [CHAN_W-1:0] scale_prod(input logic signed [SUM_W-1:0] y);
		logic [Z_W-1:0] z;
		logic [Z_W-SCALE_SHIFT-1:0] q;
		z = Z_W'($unsigned(y)) * Z_W'(SCALE_MUL);
		q = z[Z_W-1:SCALE_SHIFT];
		if (y[SUM_W-1] || y == SUM_W'(0))
			return '0;
		else if (q > (Z_W-SCALE_SHIFT)'(CHAN_MAX))
			return CHAN_W'(CHAN_MAX);
		else
			return q[CHAN_W-1:0];
	endfunction

	// floor(255 * v / 2^LEVEL_FRAC), clipped at 255
	function automatic logic [CHAN_W-1:0] scale_level(input logic [LEVEL_W-1:0] lvl);
		logic [LP_W-1:0] p;
		logic [LP_W-LEVEL_FRAC-1:0] q;
		p = LP_W'(lvl) * LP_W'(CHAN_MAX);
		q = p[LP_W-1:LEVEL_FRAC];
		if (q > (LP_W-LEVEL_FRAC)'(CHAN_MAX))
			return CHAN_W'(CHAN_MAX);
		else
			return q[CHAN_W-1:0];
	endfunction

	logic                      adv4, adv5;
	logic                      valid_s4, valid_s5;
	sector_t                   sector_s4;
	logic [LEVEL_W-1:0]        level_s4;
	logic signed [SUM_W-1:0]   mixsum_s4;
	logic signed [SUM_W-1:0]   base_s4;
	logic [CHAN_W-1:0]         red_s5, green_s5, blue_s5;

	logic [CHAN_W-1:0]         ch_full, ch_ramp, ch_base;
	logic [CHAN_W-1:0]         red_d, green_d, blue_d;

	assign adv5      = !valid_s5 || rgb_ready;
	assign adv4      = !valid_s4 || adv5;
	assign mul_ready = adv4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else if (adv4)
			valid_s4 <= mul_valid;
	end

	always_ff @(posedge clk) begin
		if (adv4 && mul_valid) begin
			sector_s4 <= mul.sector;
			level_s4  <= mul.level;
			mixsum_s4 <= $signed(SUM_W'(mul.prod_x)) + SUM_W'(mul.prod_m);
			base_s4   <= SUM_W'(mul.prod_m);
		end
	end

	always_comb begin
		ch_full = scale_level(level_s4);
		ch_ramp = scale_prod(mixsum_s4);
		ch_base = scale_prod(base_s4);
		case (sector_s4)
			SECTOR_RED_YELLOW: begin
				red_d = ch_full; green_d = ch_ramp; blue_d = ch_base;
			end
			SECTOR_YELLOW_GREEN: begin
				red_d = ch_ramp; green_d = ch_full; blue_d = ch_base;
			end
			SECTOR_GREEN_CYAN: begin
				red_d = ch_base; green_d = ch_full; blue_d = ch_ramp;
			end
			SECTOR_CYAN_BLUE: begin
				red_d = ch_base; green_d = ch_ramp; blue_d = ch_full;
			end
			SECTOR_BLUE_MAGENTA: begin
				red_d = ch_ramp; green_d = ch_base; blue_d = ch_full;
			end
			SECTOR_MAGENTA_RED: begin
				red_d = ch_full; green_d = ch_base; blue_d = ch_ramp;
			end
			default: begin
				// hue at or past 360 degrees: gray at level m
				red_d = ch_base; green_d = ch_base; blue_d = ch_base;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s5 <= 1'b0;
		else if (adv5)
			valid_s5 <= valid_s4;
	end

	always_ff @(posedge clk) begin
		if (adv5 && valid_s4) begin
			red_s5   <= red_d;
			green_s5 <= green_d;
			blue_s5  <= blue_d;
		end
	end

	assign rgb_valid = valid_s5;
	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;

	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !adv5 |=> valid_s4 && $stable(mixsum_s4) && $stable(sector_s4))
		else $error("stage 4 item changed while stalled");

endmodule
